// ----- design/cclut_pkg.sv -----
package cclut_pkg;

   localparam int MAX_EDGE_DEF    = 17;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int DATA_W          = 16;
   localparam int INDEX_W         = 13;
   localparam int EDGE_W          = 5;
   localparam int GUARD_BITS      = 8;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;

   localparam logic signed [DATA_W-1:0] ZERO_Q = 16'sd0;
   localparam logic signed [DATA_W-1:0] ONE_Q  = 16'sd4096;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef sample_type [2:0] rgb_type;

   typedef enum logic [0:0] {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CUBE_EDGE  = 3'd0,
      CSR_RED_LOW    = 3'd1,
      CSR_RED_HIGH   = 3'd2,
      CSR_GREEN_LOW  = 3'd3,
      CSR_GREEN_HIGH = 3'd4,
      CSR_BLUE_LOW   = 3'd5,
      CSR_BLUE_HIGH  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      NORM_ZERO = 2'd0,
      NORM_FULL = 2'd1,
      NORM_DIV  = 2'd2
   } norm_mode_type;

   typedef struct packed {
      op_type              opcode;
      logic [INDEX_W-1:0]  entry_index;
      sample_type          entry_red;
      sample_type          entry_green;
      sample_type          entry_blue;
      sample_type          pixel_red;
      sample_type          pixel_green;
      sample_type          pixel_blue;
   } req_type;

   typedef struct packed {
      sample_type out_red;
      sample_type out_green;
      sample_type out_blue;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      logic    pass;
      req_type req;
   } side_type;

endpackage

// ----- design/cclut_ram.sv -----
module cclut_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4913,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cclut_norm_div.sv -----
module cclut_norm_div #(
   parameter int SAMPLE_BITS = cclut_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   en,
   input  cclut_pkg::sample_type  value,
   input  cclut_pkg::sample_type  low,
   input  cclut_pkg::sample_type  high,
   output logic [SAMPLE_BITS:0]   t
);
   import cclut_pkg::*;

   localparam int SB = SAMPLE_BITS;

   logic signed [DATA_W:0] span;
   logic signed [DATA_W:0] num;
   logic signed [DATA_W:0] span_mag;
   logic signed [DATA_W:0] num_adj;
   norm_mode_type          mode_in0;

   norm_mode_type     mode_ff [SB+1];
   logic [DATA_W-1:0] rem_ff  [SB+1];
   logic [DATA_W-1:0] den_ff  [SB+1];
   logic [SB-1:0]     q_ff    [SB+1];

   logic [DATA_W-1:0] rem_in [SB+1];
   logic [SB-1:0]     q_in   [SB+1];

   // map onto [0,1], fold a negative span
   always_comb begin
      span     = (DATA_W+1)'(high) - (DATA_W+1)'(low);
      num      = (DATA_W+1)'(value) - (DATA_W+1)'(low);
      span_mag = span[DATA_W] ? -span : span;
      num_adj  = span[DATA_W] ? -num : num;
      if (span == '0 || num_adj[DATA_W] || num_adj == '0) begin
         mode_in0 = NORM_ZERO;
      end else if (num_adj >= span_mag) begin
         mode_in0 = NORM_FULL;
      end else begin
         mode_in0 = NORM_DIV;
      end
   end

   // one quotient bit per stage
   always_comb begin
      logic [DATA_W:0] rem2;
      rem_in[0] = num_adj[DATA_W-1:0];
      q_in[0]   = '0;
      for (int k = 1; k <= SB; k++) begin
         rem2 = {rem_ff[k-1], 1'b0};
         if (rem2 >= {1'b0, den_ff[k-1]}) begin
            rem_in[k] = DATA_W'(rem2 - {1'b0, den_ff[k-1]});
            q_in[k]   = {q_ff[k-1][SB-2:0], 1'b1};
         end else begin
            rem_in[k] = rem2[DATA_W-1:0];
            q_in[k]   = {q_ff[k-1][SB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_ff[0] <= mode_in0;
         rem_ff[0]  <= rem_in[0];
         den_ff[0]  <= span_mag[DATA_W-1:0];
         q_ff[0]    <= q_in[0];
         for (int k = 1; k <= SB; k++) begin
            mode_ff[k] <= mode_ff[k-1];
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_ff[k-1];
            q_ff[k]    <= q_in[k];
         end
      end
   end

   always_comb begin
      case (mode_ff[SB])
         NORM_FULL: t = (SB+1)'(1) << SB;
         NORM_DIV:  t = {1'b0, q_ff[SB]};
         default:   t = '0;
      endcase
   end

endmodule

// ----- design/color_cube_trilinear_lookup_top.sv -----
// Throughput: one item per cycle; a stall on rsp while a beat is held freezes the whole pipeline.
// The per-channel normalize divider (one quotient bit per stage) sets the depth;
// eight table copies give all eight corner reads in one cycle.
// Loads write the table in the read stage and produce no rsp beat.
// Reset clears valid bits and sets the configuration registers to their defaults; table stays unknown.
module color_cube_trilinear_lookup_top #(
   parameter int MAX_EDGE    = cclut_pkg::MAX_EDGE_DEF,
   parameter int SAMPLE_BITS = cclut_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cclut_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cclut_pkg::rsp_type               rsp_data,
   input  logic                             csr_write,
   input  logic [cclut_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cclut_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cclut_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = $clog2(MAX_EDGE + 1);
   localparam int IW    = $clog2(MAX_EDGE);
   localparam int RW    = $clog2(MAX_EDGE * MAX_EDGE);
   localparam int FW    = SB + 1 + IW;
   localparam int GW    = DATA_W + GUARD_BITS;
   localparam int DW    = GW + 1;
   localparam int PW    = DW + SB + 1;
   localparam int XW    = GW + 1;
   localparam int DL    = SB + 1;

   // ---------------- configuration ----------------
   logic [EDGE_W-1:0] cube_edge_ff;
   sample_type        low_ff  [3];
   sample_type        high_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cube_edge_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            low_ff[c]  <= ZERO_Q;
            high_ff[c] <= ONE_Q;
         end
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CUBE_EDGE:  cube_edge_ff <= csr_data[EDGE_W-1:0];
            CSR_RED_LOW:    low_ff[0]    <= sample_type'(csr_data);
            CSR_RED_HIGH:   high_ff[0]   <= sample_type'(csr_data);
            CSR_GREEN_LOW:  low_ff[1]    <= sample_type'(csr_data);
            CSR_GREEN_HIGH: high_ff[1]   <= sample_type'(csr_data);
            CSR_BLUE_LOW:   low_ff[2]    <= sample_type'(csr_data);
            CSR_BLUE_HIGH:  high_ff[2]   <= sample_type'(csr_data);
            default: ;
         endcase
      end
   end

   logic [EW-1:0] dim;
   logic          pass;
   logic [IW-1:0] dim_m1;

   always_comb begin
      dim    = (int'(cube_edge_ff) > MAX_EDGE) ? EW'(MAX_EDGE) : EW'(cube_edge_ff);
      pass   = (dim < EW'(2));
      dim_m1 = pass ? '0 : IW'(dim - EW'(1));
   end

   // ---------------- arithmetic helpers ----------------
   function automatic logic signed [PW-1:0] lerp_prod(input logic signed [GW-1:0] a_v,
                                                      input logic signed [GW-1:0] b_v,
                                                      input logic [SB-1:0] w);
      logic signed [DW-1:0] diff;
      diff = DW'(b_v) - DW'(a_v);
      return PW'(diff) * $signed({1'b0, w});
   endfunction

   function automatic logic signed [GW-1:0] lerp_sum(input logic signed [GW-1:0] a_v,
                                                     input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = PW'(a_v) + (p >>> SB);
      return s[GW-1:0];
   endfunction

   function automatic sample_type round_out(input logic signed [GW-1:0] x);
      logic signed [XW-1:0] s;
      s = XW'(x) + XW'(1 << (GUARD_BITS - 1));
      return s[GW-1:GUARD_BITS];
   endfunction

   // ---------------- pipeline control ----------------
   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // input stage
   logic    s0_valid_ff;
   req_type s0_req_ff;

   // ---------------- normalize dividers ----------------
   sample_type        pix [3];
   logic [SB:0]       t_val [3];

   assign pix[0] = s0_req_ff.pixel_red;
   assign pix[1] = s0_req_ff.pixel_green;
   assign pix[2] = s0_req_ff.pixel_blue;

   for (genvar c = 0; c < 3; c++) begin : g_div
      cclut_norm_div #(.SAMPLE_BITS(SB)) u_div (
         .clock (clock),
         .en    (adv),
         .value (pix[c]),
         .low   (low_ff[c]),
         .high  (high_ff[c]),
         .t     (t_val[c])
      );
   end

   // ---------------- stage registers ----------------
   side_type line_ff [DL];
   side_type sf_side_ff, sm_side_ff, rd_side_ff;
   side_type b1_side_ff, b2_side_ff, b3_side_ff, b4_side_ff, b5_side_ff;

   logic [FW-1:0]        f_ff [3];
   logic [2:0][SB-1:0]   sm_w_ff, rd_w_ff, b1_w_ff, b2_w_ff, b3_w_ff, b4_w_ff;
   logic [RW-1:0]        row_ff [4];
   logic [IW-1:0]        r_ff [2];

   logic signed [GW-1:0] b1_a_ff [3][4];
   logic signed [PW-1:0] b1_p_ff [3][4];
   logic signed [GW-1:0] b2_c_ff [3][4];
   logic signed [GW-1:0] b3_a_ff [3][2];
   logic signed [PW-1:0] b3_p_ff [3][2];
   logic signed [GW-1:0] b4_c_ff [3][2];
   logic signed [GW-1:0] b5_a_ff [3];
   logic signed [PW-1:0] b5_p_ff [3];

   // locate cell per channel
   logic [IW-1:0] i0 [3];
   logic [IW-1:0] i1 [3];
   logic [SB-1:0] w_in [3];

   always_comb begin
      logic [IW:0] i_full;
      for (int c = 0; c < 3; c++) begin
         i_full  = f_ff[c][FW-1:SB];
         i0[c]   = (i_full > (IW+1)'(dim_m1)) ? dim_m1 : i_full[IW-1:0];
         i1[c]   = (i0[c] == dim_m1) ? dim_m1 : IW'(i0[c] + IW'(1));
         w_in[c] = f_ff[c][SB-1:0];
      end
   end

   logic [RW-1:0] row_in [4];

   always_comb begin
      logic [IW-1:0] bi;
      logic [IW-1:0] gi;
      for (int j = 0; j < 4; j++) begin
         bi        = j[1] ? i1[2] : i0[2];
         gi        = j[0] ? i1[1] : i0[1];
         row_in[j] = RW'(bi) * RW'(dim) + RW'(gi);
      end
   end

   // ---------------- table copies ----------------
   logic [AW-1:0] rd_addr [8];
   rgb_type       corner  [8];
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   rgb_type       wr_data;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         rd_addr[k] = AW'(row_ff[k >> 1]) * AW'(dim) + AW'(r_ff[k & 1]);
      end
      wr_en      = adv && sm_side_ff.valid && (sm_side_ff.req.opcode == OP_LOAD) &&
                   (int'(sm_side_ff.req.entry_index) < DEPTH);
      wr_addr    = AW'(sm_side_ff.req.entry_index);
      wr_data[0] = sm_side_ff.req.entry_red;
      wr_data[1] = sm_side_ff.req.entry_green;
      wr_data[2] = sm_side_ff.req.entry_blue;
   end

   for (genvar k = 0; k < 8; k++) begin : g_bank
      cclut_ram #(.WIDTH($bits(rgb_type)), .DEPTH(DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (adv),
         .rd_addr (rd_addr[k]),
         .rd_data (corner[k])
      );
   end

   // ---------------- blend and output ----------------
   rsp_type rsp_data_in;

   always_comb begin
      logic signed [GW-1:0] x;
      sample_type           y [3];
      for (int c = 0; c < 3; c++) begin
         x    = lerp_sum(b5_a_ff[c], b5_p_ff[c]);
         y[c] = round_out(x);
      end
      if (b5_side_ff.pass) begin
         rsp_data_in.out_red   = b5_side_ff.req.pixel_red;
         rsp_data_in.out_green = b5_side_ff.req.pixel_green;
         rsp_data_in.out_blue  = b5_side_ff.req.pixel_blue;
      end else begin
         rsp_data_in.out_red   = y[0];
         rsp_data_in.out_green = y[1];
         rsp_data_in.out_blue  = y[2];
      end
   end

   // valid bits and side data
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         for (int k = 0; k < DL; k++) begin
            line_ff[k].valid <= 1'b0;
         end
         sf_side_ff.valid <= 1'b0;
         sm_side_ff.valid <= 1'b0;
         rd_side_ff.valid <= 1'b0;
         b1_side_ff.valid <= 1'b0;
         b2_side_ff.valid <= 1'b0;
         b3_side_ff.valid <= 1'b0;
         b4_side_ff.valid <= 1'b0;
         b5_side_ff.valid <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
         line_ff[0]  <= '{valid: s0_valid_ff, pass: pass, req: s0_req_ff};
         for (int k = 1; k < DL; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
         sf_side_ff   <= line_ff[DL-1];
         sm_side_ff   <= sf_side_ff;
         rd_side_ff   <= sm_side_ff;
         b1_side_ff   <= rd_side_ff;
         b2_side_ff   <= b1_side_ff;
         b3_side_ff   <= b2_side_ff;
         b4_side_ff   <= b3_side_ff;
         b5_side_ff   <= b4_side_ff;
         // loads end here without a beat
         rsp_valid_ff <= b5_side_ff.valid && (b5_side_ff.req.opcode == OP_SAMPLE);
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_req_ff <= req_data;
         for (int c = 0; c < 3; c++) begin
            f_ff[c]       <= FW'(t_val[c]) * FW'(dim_m1);
            sm_w_ff[c]    <= w_in[c];
         end
         for (int j = 0; j < 4; j++) begin
            row_ff[j] <= row_in[j];
         end
         r_ff[0] <= i0[0];
         r_ff[1] <= i1[0];
         rd_w_ff <= sm_w_ff;
         b1_w_ff <= rd_w_ff;
         b2_w_ff <= b1_w_ff;
         b3_w_ff <= b2_w_ff;
         b4_w_ff <= b3_w_ff;
         for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 4; j++) begin
               b1_a_ff[c][j] <= $signed({corner[2*j][c], {GUARD_BITS{1'b0}}});
               b1_p_ff[c][j] <= lerp_prod($signed({corner[2*j][c], {GUARD_BITS{1'b0}}}),
                                          $signed({corner[2*j+1][c], {GUARD_BITS{1'b0}}}),
                                          rd_w_ff[0]);
               b2_c_ff[c][j] <= lerp_sum(b1_a_ff[c][j], b1_p_ff[c][j]);
            end
            for (int m = 0; m < 2; m++) begin
               b3_a_ff[c][m] <= b2_c_ff[c][2*m];
               b3_p_ff[c][m] <= lerp_prod(b2_c_ff[c][2*m], b2_c_ff[c][2*m+1], b2_w_ff[1]);
               b4_c_ff[c][m] <= lerp_sum(b3_a_ff[c][m], b3_p_ff[c][m]);
            end
            b5_a_ff[c] <= b4_c_ff[c][0];
            b5_p_ff[c] <= lerp_prod(b4_c_ff[c][0], b4_c_ff[c][1], b4_w_ff[2]);
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/cclut_checker.sv -----
module cclut_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  cclut_pkg::req_type                req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  cclut_pkg::rsp_type                rsp_data,
   input  logic                              csr_write,
   input  logic [cclut_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cclut_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                fail_count,
   output int                                pending
);
   import cclut_pkg::*;

   localparam int DEPTH = MAX_EDGE_DEF * MAX_EDGE_DEF * MAX_EDGE_DEF;

   // channel 2 is red, 1 green, 0 blue, matching the packed order of rgb_type
   rgb_type          color_mem [DEPTH];
   logic [EDGE_W-1:0] edge_cfg;
   sample_type       dom_lo [3];
   sample_type       dom_hi [3];
   rsp_type          expected_pixels [$];

   initial fail_count = 0;
   assign pending = expected_pixels.size();

   function automatic longint norm_pos(longint v, longint lo, longint hi);
      longint span;
      longint num;
      span = hi - lo;
      num  = v - lo;
      if (span == 0) return 0;
      if (span < 0) begin
         span = -span;
         num  = -num;
      end
      if (num <= 0) return 0;
      if (num >= span) return longint'(1) << SAMPLE_BITS_DEF;
      return (num << SAMPLE_BITS_DEF) / span;
   endfunction

   function automatic longint blend(longint a, longint b, longint w);
      return a + (((b - a) * w) >>> SAMPLE_BITS_DEF);
   endfunction

   function automatic longint corner_val(int d, int r, int g, int b, int ch);
      rgb_type e;
      e = color_mem[(b * d + g) * d + r];
      return longint'(e[ch]) * (longint'(1) << GUARD_BITS);
   endfunction

   function automatic rsp_type interpolate(req_type q);
      rsp_type   res;
      rgb_type   outv;
      sample_type pix [3];
      int        lo_i [3];
      int        hi_i [3];
      longint    wt [3];
      longint    f;
      longint    c00, c10, c01, c11, c0, c1, x;
      int        d;
      pix[2] = q.pixel_red;
      pix[1] = q.pixel_green;
      pix[0] = q.pixel_blue;
      d = (edge_cfg > MAX_EDGE_DEF) ? MAX_EDGE_DEF : int'(edge_cfg);
      if (d < 2) begin
         res.out_red   = q.pixel_red;
         res.out_green = q.pixel_green;
         res.out_blue  = q.pixel_blue;
         return res;
      end
      for (int c = 0; c < 3; c++) begin
         f = norm_pos(pix[c], dom_lo[c], dom_hi[c]) * (d - 1);
         lo_i[c] = int'(f >>> SAMPLE_BITS_DEF);
         if (lo_i[c] > d - 1) lo_i[c] = d - 1;
         hi_i[c] = (lo_i[c] + 1 > d - 1) ? d - 1 : lo_i[c] + 1;
         wt[c] = f - (longint'(lo_i[c]) << SAMPLE_BITS_DEF);
      end
      // red first, then green, then blue
      for (int ch = 0; ch < 3; ch++) begin
         c00 = blend(corner_val(d, lo_i[2], lo_i[1], lo_i[0], ch),
                     corner_val(d, hi_i[2], lo_i[1], lo_i[0], ch), wt[2]);
         c10 = blend(corner_val(d, lo_i[2], hi_i[1], lo_i[0], ch),
                     corner_val(d, hi_i[2], hi_i[1], lo_i[0], ch), wt[2]);
         c01 = blend(corner_val(d, lo_i[2], lo_i[1], hi_i[0], ch),
                     corner_val(d, hi_i[2], lo_i[1], hi_i[0], ch), wt[2]);
         c11 = blend(corner_val(d, lo_i[2], hi_i[1], hi_i[0], ch),
                     corner_val(d, hi_i[2], hi_i[1], hi_i[0], ch), wt[2]);
         c0 = blend(c00, c10, wt[1]);
         c1 = blend(c01, c11, wt[1]);
         x  = blend(c0, c1, wt[0]);
         outv[ch] = sample_type'((x + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS);
      end
      res.out_red   = outv[2];
      res.out_green = outv[1];
      res.out_blue  = outv[0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         edge_cfg <= '0;
         for (int c = 0; c < 3; c++) begin
            dom_lo[c] <= ZERO_Q;
            dom_hi[c] <= ONE_Q;
         end
         expected_pixels.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CUBE_EDGE:  edge_cfg  <= csr_data[EDGE_W-1:0];
               CSR_RED_LOW:    dom_lo[2] <= csr_data;
               CSR_RED_HIGH:   dom_hi[2] <= csr_data;
               CSR_GREEN_LOW:  dom_lo[1] <= csr_data;
               CSR_GREEN_HIGH: dom_hi[1] <= csr_data;
               CSR_BLUE_LOW:   dom_lo[0] <= csr_data;
               CSR_BLUE_HIGH:  dom_hi[0] <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_data.opcode == OP_LOAD) begin
               if (req_data.entry_index < DEPTH)
                  color_mem[req_data.entry_index] <=
                     {req_data.entry_red, req_data.entry_green, req_data.entry_blue};
            end else begin
               expected_pixels = {expected_pixels, interpolate(req_data)};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected rsp beat %h", rsp_data);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.out_red !== want.out_red) begin
                  $error("out_red expected %0d actual %0d", want.out_red, rsp_data.out_red);
                  fail_count++;
               end
               if (rsp_data.out_green !== want.out_green) begin
                  $error("out_green expected %0d actual %0d",
                         want.out_green, rsp_data.out_green);
                  fail_count++;
               end
               if (rsp_data.out_blue !== want.out_blue) begin
                  $error("out_blue expected %0d actual %0d", want.out_blue, rsp_data.out_blue);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ----- tb/tb_color_cube_trilinear_lookup_top.sv -----
module tb_color_cube_trilinear_lookup_top;
   import cclut_pkg::*;

   localparam int  LATENCY_WAIT = 60;
   localparam int  CYCLE_LIMIT  = 1500000;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONE = 3'd7;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_write = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending;
   int idle_mode = 0;
   int cycles = 0;
   int sent = 0;
   int dlo [3];
   int dhi [3];

   color_cube_trilinear_lookup_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   cclut_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial forever #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset || idle_mode == 0 || idle_mode == 1) rsp_stall <= 1'b0;
      else rsp_stall <= $urandom_range(99) < ((idle_mode == 2) ? 60 : 16);
   end

   function automatic req_type noise_req();
      req_type q;
      q = req_type'({$urandom, $urandom, $urandom, $urandom});
      return q;
   endfunction

   // start and end at a falling edge
   task automatic send(req_type q);
      int gap_pct;
      gap_pct = (idle_mode == 1) ? 60 : (idle_mode == 3) ? 16 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
      if (sent % 97 == 0) idle_mode = (idle_mode + 1) % 4;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (LATENCY_WAIT) @(negedge clock);
   endtask

   task automatic csr_put(logic [CSR_INDEX_W-1:0] idx, int val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_domains(int rl, int rh, int gl, int gh, int bl, int bh);
      dlo[2] = rl; dhi[2] = rh; dlo[1] = gl; dhi[1] = gh; dlo[0] = bl; dhi[0] = bh;
      csr_put(CSR_RED_LOW, rl);
      csr_put(CSR_RED_HIGH, rh);
      csr_put(CSR_GREEN_LOW, gl);
      csr_put(CSR_GREEN_HIGH, gh);
      csr_put(CSR_BLUE_LOW, bl);
      csr_put(CSR_BLUE_HIGH, bh);
   endtask

   task automatic load_entry(int idx);
      req_type q;
      q = noise_req();
      q.opcode = OP_LOAD;
      q.entry_index = idx[INDEX_W-1:0];
      send(q);
   endtask

   task automatic fill_cube(int d);
      for (int i = 0; i < d * d * d; i++) load_entry(i);
   endtask

   task automatic sample_px(int r, int g, int b);
      req_type q;
      q = noise_req();
      q.opcode = OP_SAMPLE;
      q.pixel_red = r[15:0];
      q.pixel_green = g[15:0];
      q.pixel_blue = b[15:0];
      send(q);
   endtask

   function automatic int domain_pick(int c);
      int lo;
      int hi;
      lo = (dlo[c] < dhi[c]) ? dlo[c] : dhi[c];
      hi = (dlo[c] < dhi[c]) ? dhi[c] : dlo[c];
      if ($urandom_range(9) < 7) return lo + int'($urandom_range(hi - lo));
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int rand_bound();
      case ($urandom_range(3))
         0: return -32768;
         1: return 32767;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   task automatic random_domains(bit flat_blue);
      int v [6];
      for (int k = 0; k < 6; k++) v[k] = rand_bound();
      // sometimes collapse a span to zero
      if ($urandom_range(3) == 0) v[1] = v[0];
      // keep blue on the first cell so reads stay in the loaded planes
      if (flat_blue) v[5] = v[4];
      set_domains(v[0], v[1], v[2], v[3], v[4], v[5]);
   endtask

   task automatic random_traffic(int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) < 2) begin
            load_entry(int'($urandom_range(8191)));
         end else begin
            sample_px(domain_pick(2), domain_pick(1), domain_pick(0));
            n++;
         end
      end
   endtask

   task automatic edge_phase(int d, int count);
      settle();
      csr_put(CSR_CUBE_EDGE, d);
      random_domains(d > 8);
      random_traffic(count);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      dlo = '{0, 0, 0};
      dhi = '{4096, 4096, 4096};

      // pass-through at reset, plus out-of-range and last valid load index
      sample_px(-32768, 32767, 0);
      sample_px(-1, 0, 32767);
      load_entry(8191);
      load_entry(4913);
      load_entry(4912);

      settle();
      csr_put(CSR_NONE, 16'hffff);
      csr_put(CSR_CUBE_EDGE, 2);
      fill_cube(2);
      sample_px(0, 0, 0);
      sample_px(4096, 4096, 4096);
      sample_px(-1, 4097, 2048);
      sample_px(-32768, 32767, 1);
      sample_px(2048, 1024, 3072);

      // reversed and zero-span domains at full width
      settle();
      csr_put(CSR_CUBE_EDGE, 17);
      set_domains(-32768, 32767, 32767, -32768, 5, 5);
      // zero blue span reads only the first two blue planes
      for (int i = 0; i < 2 * MAX_EDGE_DEF * MAX_EDGE_DEF; i++) load_entry(i);
      sample_px(-32768, -32768, -32768);
      sample_px(32767, 32767, 32767);
      sample_px(0, 0, 0);
      sample_px(32766, -32767, 6);
      random_traffic(60);

      // edge above the maximum saturates
      edge_phase(31, 60);
      edge_phase(3, 80);
      edge_phase(4, 60);
      edge_phase(5, 60);
      edge_phase(2, 50);
      edge_phase(1, 30);
      edge_phase(8, 60);

      settle();
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
design/cclut_pkg.sv
design/cclut_ram.sv
design/cclut_norm_div.sv
design/color_cube_trilinear_lookup_top.sv
tb/cclut_checker.sv
tb/tb_color_cube_trilinear_lookup_top.sv
